// ===== design/gnms_pkg.sv =====
// Shared types for the gradient non-maximum suppression block.
package gnms_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_LHS,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_CHK,
        S_DONE
    } t_state;

    localparam int unsigned SMALL_LIMIT = 3;
    localparam int unsigned SAT_ROOT    = 3264;
    localparam int unsigned SCALE_SQ    = 400;
    localparam logic [7:0]  SAT_OUT     = 8'd255;
    localparam logic        REG_WIDTH   = 1'b0;
    localparam logic        REG_HEIGHT  = 1'b1;

endpackage

// ===== design/gradient_nonmax_suppression_top.sv =====
// Canny-style non-maximum suppression over a raster stream of gradient pairs.
//
// One gradient pair per pixel enters in raster order; two line memories (each MAX_WIDTH
// entries, read at the column, written back in the next cycle) and a 3x2 window give the
// 3x3 neighbourhood. Interior pixels give one result, border pixels none. The block works
// on one pixel at a time: a border pixel passes the read state only, a pixel with both
// components below 3 LSB goes straight to the done state, a pixel that is suppressed or
// saturates runs five 32-step magnitudes and the comparison steps, and any other interior
// pixel adds one 32-step scaled root; the square-root unit takes one bit per cycle.
// The done state waits while the output register holds a result not yet taken.
// Writing either register restarts the frame at row 0, column 0.
module gradient_nonmax_suppression_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int GRAD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // grad_x, grad_y (low bits first), zero padded to bytes
    input  logic [((2*GRAD_BITS+7)/8)*8-1:0]      i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // edge_magnitude
    output logic [7:0]                            o_m_tdata,
    output logic                                  o_m_tlast,
    // frame_end
    output logic                                  o_m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import gnms_pkg::*;

    localparam int G   = GRAD_BITS;
    localparam int PW  = 2 * G;
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW  = G + 32;
    localparam int SHF = 64 - 2 * G;

    t_state r_state, n_state;

    logic [10:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [CW-1:0] r_col;
    logic [11:0] r_row;
    logic [31:0] w_eff, h_eff;
    logic cfg_wr, accept;

    logic [PW-1:0] mem_a [MAX_WIDTH];
    logic [PW-1:0] mem_b [MAX_WIDTH];
    logic [PW-1:0] r_rd_a, r_rd_b, r_cur;
    logic [CW-1:0] r_wcol;
    logic [PW-1:0] r_win [3][2];

    logic r_emit, r_rend, r_fend;
    logic [PW-1:0] r_p [5];
    logic [31:0]   r_m [5];
    logic [2:0]    r_k;
    logic [G-1:0]  r_a, r_b;
    logic [PW-1:0] r_acc;
    logic [63:0]   r_s0;
    logic [63:0]   r_sv, r_sr, r_sbit;
    logic          r_final;
    logic [MW-1:0] r_lhs, r_t;
    logic          r_ok;
    logic [7:0]    r_res;
    logic          r_ov;
    logic [7:0]    r_omag;
    logic          r_olast, r_ouser;

    function automatic logic [G-1:0] abs_g(input logic [G-1:0] v);
        return v[G-1] ? (~v + 1'b1) : v;
    endfunction

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite & pready;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid & o_s_tready;
    assign prdata     = (paddr[2] == REG_HEIGHT) ? {19'b0, r_frame_height}
                                                 : {21'b0, r_frame_width};

    always_comb begin
        w_eff = {21'b0, r_frame_width};
        if (w_eff < 32'd3) w_eff = 32'd3;
        else if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
        h_eff = {19'b0, r_frame_height};
        if (h_eff < 32'd3) h_eff = 32'd3;
        else if (h_eff > 32'd4096) h_eff = 32'd4096;
    end

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 13'd480;
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) r_frame_height <= pwdata[12:0];
            else                        r_frame_width  <= pwdata[10:0];
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (32'(r_col) + 32'd1 >= w_eff) begin
                r_col <= '0;
                r_row <= (32'(r_row) + 32'd1 >= h_eff) ? 12'd0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // line memories: read at acceptance, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (accept) r_rd_a <= mem_a[r_col];
        if (r_state == S_READ) mem_a[r_wcol] <= r_rd_b;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_rd_b <= mem_b[r_col];
        if (r_state == S_READ) mem_b[r_wcol] <= r_cur;
    end

    // square-root step
    logic [63:0] sq_trial;
    logic        sq_ge;
    assign sq_trial = r_sr + r_sbit;
    assign sq_ge    = (r_sv >= sq_trial);

    // neighbour selection
    logic [G-1:0] cx, cy, ax, ay;
    logic pos, ydom;
    assign cx   = r_win[1][1][G-1:0];
    assign cy   = r_win[1][1][PW-1:G];
    assign ax   = abs_g(cx);
    assign ay   = abs_g(cy);
    assign pos  = ((cx != '0) && (cy != '0)) && (cx[G-1] == cy[G-1]);
    assign ydom = (ay > ax);

    logic [G-1:0] px, py;
    assign px = abs_g(r_p[r_k][G-1:0]);
    assign py = abs_g(r_p[r_k][PW-1:G]);

    logic [PW-1:0] sq_sum;
    assign sq_sum = r_acc + PW'(py * py);

    logic [G-1:0] bma;
    assign bma = r_b - r_a;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ: begin
                if (!r_emit) n_state = S_IDLE;
                else if (32'(ax) < SMALL_LIMIT && 32'(ay) < SMALL_LIMIT) n_state = S_DONE;
                else n_state = S_SQX;
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_ROOT;
            S_ROOT: begin
                if (r_sbit[0]) begin
                    if (r_final) n_state = S_DONE;
                    else if (r_k == 3'd4) n_state = S_LHS;
                    else n_state = S_SQX;
                end
            end
            S_LHS:   n_state = S_T1;
            S_T1:    n_state = S_T2;
            S_T2:    n_state = S_T3;
            S_T3:    n_state = S_T4;
            S_T4:    n_state = S_CHK;
            S_CHK: begin
                if (!(r_ok && r_lhs > r_t)) n_state = S_DONE;
                else if (r_s0 >= 64'(SAT_ROOT * SAT_ROOT)) n_state = S_DONE;
                else n_state = S_ROOT;
            end
            S_DONE:  if (!r_ov || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= '0;
                r_win[r][1] <= '0;
            end
        end else if (r_state == S_READ) begin
            r_win[0][0] <= r_win[0][1];
            r_win[0][1] <= r_rd_a;
            r_win[1][0] <= r_win[1][1];
            r_win[1][1] <= r_rd_b;
            r_win[2][0] <= r_win[2][1];
            r_win[2][1] <= r_cur;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cur  <= i_s_tdata[PW-1:0];
                    r_wcol <= r_col;
                    r_emit <= (r_row >= 12'd2) && (32'(r_col) >= 32'd2);
                    r_rend <= (32'(r_col) == w_eff - 32'd1);
                    r_fend <= (32'(r_col) == w_eff - 32'd1) && (32'(r_row) == h_eff - 32'd1);
                end
            end
            S_READ: begin
                r_p[0]  <= r_win[1][1];
                r_k     <= '0;
                r_final <= 1'b0;
                r_res   <= '0;
                if (ydom) begin
                    r_a <= ax; r_b <= ay;
                    r_p[2] <= r_win[0][1];
                    r_p[4] <= r_win[2][1];
                    if (pos) begin r_p[3] <= r_cur;       r_p[1] <= r_win[0][0]; end
                    else     begin r_p[3] <= r_win[2][0]; r_p[1] <= r_rd_a;      end
                end else begin
                    r_a <= ay; r_b <= ax;
                    r_p[2] <= r_rd_b;
                    r_p[4] <= r_win[1][0];
                    if (pos) begin r_p[3] <= r_win[0][0]; r_p[1] <= r_cur;  end
                    else     begin r_p[3] <= r_win[2][0]; r_p[1] <= r_rd_a; end
                end
            end
            S_SQX: r_acc <= PW'(px * px);
            S_SQY: begin
                if (r_k == 3'd0) r_s0 <= 64'(sq_sum);
                r_sv   <= 64'(sq_sum) << SHF;
                r_sr   <= '0;
                r_sbit <= 64'd1 << 62;
            end
            S_ROOT: begin
                if (sq_ge) begin
                    r_sv <= r_sv - sq_trial;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
                if (r_sbit[0]) begin
                    if (r_final) begin
                        r_res <= 8'(sq_ge ? (((r_sr >> 1) + r_sbit) >> 8) : (r_sr >> 9));
                    end else begin
                        r_m[r_k] <= sq_ge ? 32'((r_sr >> 1) + r_sbit) : 32'(r_sr >> 1);
                        r_k <= r_k + 3'd1;
                    end
                end
            end
            S_LHS: r_lhs <= MW'(r_b * r_m[0]);
            S_T1:  r_t   <= MW'(r_a * r_m[1]);
            S_T2:  r_t   <= r_t + MW'(bma * r_m[2]);
            S_T3: begin
                r_ok <= (r_lhs > r_t);
                r_t  <= MW'(r_a * r_m[3]);
            end
            S_T4:  r_t   <= r_t + MW'(bma * r_m[4]);
            S_CHK: begin
                if (r_ok && r_lhs > r_t) begin
                    if (r_s0 >= 64'(SAT_ROOT * SAT_ROOT)) begin
                        r_res <= SAT_OUT;
                    end else begin
                        r_sv    <= 64'(r_s0[23:0] * 9'(SCALE_SQ));
                        r_sr    <= '0;
                        r_sbit  <= 64'd1 << 62;
                        r_final <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DONE && (!r_ov || i_m_tready)) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ov || i_m_tready)) begin
            r_omag  <= r_res;
            r_olast <= r_rend;
            r_ouser <= r_fend;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_omag;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

endmodule
